// ===== rtl/core/sddf_pkg.sv =====
package sddf_pkg;

    localparam int MAX_DIGITS = 6;
    localparam int MIN_DIGITS = 2;

    localparam int VALUE_W = 16;
    localparam int MAG_W   = VALUE_W - 1;
    localparam int COUNT_W = 3;
    localparam int GLYPH_W = 4;
    localparam int POS_W   = 3;
    localparam int BCD_DIGITS = 5;
    localparam int BCD_W   = 4 * BCD_DIGITS;
    localparam int STEP_W  = $clog2(MAG_W);

    localparam logic [GLYPH_W-1:0] GLYPH_MINUS  = 4'd0;
    localparam logic [GLYPH_W-1:0] GLYPH_POINT  = 4'd1;
    localparam logic [GLYPH_W-1:0] GLYPH_DIGIT0 = 4'd3;
    localparam logic [GLYPH_W-1:0] GLYPH_BLANK  = 4'd14;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_EMIT
    } state_t;

endpackage

// ===== rtl/core/sddf_item_if.sv =====
interface sddf_item_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [sddf_pkg::VALUE_W-1:0]  value;
    logic        [sddf_pkg::COUNT_W-1:0]  digit_count;
    logic                                 decimal_mode;
    logic        [sddf_pkg::COUNT_W-1:0]  keep_count;

    modport source (output valid, value, digit_count, decimal_mode, keep_count, input ready);
    modport sink   (input valid, value, digit_count, decimal_mode, keep_count, output ready);
endinterface

// ===== rtl/core/sddf_result_if.sv =====
interface sddf_result_if;
    logic                           valid;
    logic                           ready;
    logic [sddf_pkg::GLYPH_W-1:0]   glyph;
    logic [sddf_pkg::POS_W-1:0]     position;
    logic                           last;

    modport source (output valid, glyph, position, last, input ready);
    modport sink   (input valid, glyph, position, last, output ready);
endinterface

// ===== rtl/core/signed_decimal_digit_formatter.sv =====
// Signed decimal glyph formatter.
// item (sink): one request carries a signed 16-bit value, the field length
// digit_count (2 to 6, clamped), decimal_mode and keep_count.
// result (source): one request per character position, leftmost first, with
// the glyph code, its position and last on the rightmost one.
// A request is taken in idle, the magnitude is converted to five BCD digits by
// a shift-and-add-3 loop, one magnitude bit per cycle, and then one character
// per cycle is loaded into the output register while the receiver keeps ready
// high.
// The next request is taken as soon as the last character sits in the output
// register, so its conversion overlaps delivery of that last character.
// A receiver stall holds the output register and pauses character emission;
// the conversion of a request already taken still runs to its end.
// Reset empties the output register and returns the block to idle.
module signed_decimal_digit_formatter (
    input  logic               clk,
    input  logic               rst_n,
    sddf_item_if.sink          item,
    sddf_result_if.source      result
);

    sddf_pkg::state_t                 state_reg, state_next;
    logic [sddf_pkg::STEP_W-1:0]      step_reg, step_next;
    logic [sddf_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic                             blank_reg, blank_next;
    logic                             out_valid_reg, out_valid_next;

    logic [sddf_pkg::MAG_W-1:0]       mag_reg, mag_next;
    logic [sddf_pkg::BCD_W-1:0]       bcd_reg, bcd_next;
    logic [sddf_pkg::POS_W-1:0]       last_pos_reg, last_pos_next;
    logic [sddf_pkg::POS_W-1:0]       limit_reg, limit_next;
    logic                             neg_reg, neg_next;
    logic                             dec_reg, dec_next;
    logic [sddf_pkg::GLYPH_W-1:0]     glyph_reg, glyph_next;
    logic [sddf_pkg::POS_W-1:0]       opos_reg, opos_next;
    logic                             olast_reg, olast_next;

    logic                             accept;
    logic                             load;
    logic [sddf_pkg::VALUE_W-1:0]     raw;
    logic [sddf_pkg::VALUE_W-1:0]     negated;
    logic [sddf_pkg::MAG_W-1:0]       in_mag;
    logic [sddf_pkg::COUNT_W-1:0]     in_n;
    logic [sddf_pkg::BCD_W-1:0]       bcd_adj;
    logic [sddf_pkg::POS_W-1:0]       col;
    logic [sddf_pkg::POS_W-1:0]       idx;
    logic [3:0]                       digit;
    logic [sddf_pkg::GLYPH_W-1:0]     code;
    logic                             blank_now;

    assign accept = item.valid && item.ready;
    assign load   = (state_reg == sddf_pkg::ST_EMIT) && (!out_valid_reg || result.ready);

    assign result.valid    = out_valid_reg;
    assign result.glyph    = glyph_reg;
    assign result.position = opos_reg;
    assign result.last     = olast_reg;

    // saturate the most negative value, clamp the field length
    always_comb
    begin
        raw     = item.value;
        negated = (~raw) + 16'd1;
        if (!raw[sddf_pkg::VALUE_W-1])
            in_mag = raw[sddf_pkg::MAG_W-1:0];
        else if (negated[sddf_pkg::VALUE_W-1])
            in_mag = {sddf_pkg::MAG_W{1'b1}};
        else
            in_mag = negated[sddf_pkg::MAG_W-1:0];

        if (item.digit_count < sddf_pkg::COUNT_W'(sddf_pkg::MIN_DIGITS))
            in_n = sddf_pkg::COUNT_W'(sddf_pkg::MIN_DIGITS);
        else if (item.digit_count > sddf_pkg::COUNT_W'(sddf_pkg::MAX_DIGITS))
            in_n = sddf_pkg::COUNT_W'(sddf_pkg::MAX_DIGITS);
        else
            in_n = item.digit_count;
    end

    // add 3 to every BCD digit of 5 or more
    always_comb
    begin
        for (int i = 0; i < sddf_pkg::BCD_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    // glyph for the current position
    always_comb
    begin
        col = last_pos_reg - pos_reg;
        if (dec_reg && (col != '0))
            idx = col - 3'd1;
        else
            idx = col;

        unique case (idx)
            3'd0:    digit = bcd_reg[3:0];
            3'd1:    digit = bcd_reg[7:4];
            3'd2:    digit = bcd_reg[11:8];
            3'd3:    digit = bcd_reg[15:12];
            3'd4:    digit = bcd_reg[19:16];
            default: digit = 4'd0;
        endcase

        if (neg_reg && (pos_reg == '0))
            code = sddf_pkg::GLYPH_MINUS;
        else if (dec_reg && (col == 3'd1))
            code = sddf_pkg::GLYPH_POINT;
        else
            code = digit + sddf_pkg::GLYPH_DIGIT0;

        blank_now = blank_reg && (pos_reg < limit_reg) && (code == sddf_pkg::GLYPH_DIGIT0);
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        pos_next       = pos_reg;
        blank_next     = blank_reg;
        out_valid_next = out_valid_reg;
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        last_pos_next  = last_pos_reg;
        limit_next     = limit_reg;
        neg_next       = neg_reg;
        dec_next       = dec_reg;
        glyph_next     = glyph_reg;
        opos_next      = opos_reg;
        olast_next     = olast_reg;
        item.ready     = 1'b0;

        if (result.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            sddf_pkg::ST_IDLE:
            begin
                item.ready = 1'b1;
                if (item.valid)
                begin
                    mag_next      = in_mag;
                    bcd_next      = '0;
                    neg_next      = raw[sddf_pkg::VALUE_W-1];
                    dec_next      = item.decimal_mode;
                    last_pos_next = in_n - 3'd1;
                    if (item.keep_count >= in_n)
                        limit_next = '0;
                    else
                        limit_next = in_n - item.keep_count;
                    step_next  = '0;
                    state_next = sddf_pkg::ST_CONVERT;
                end
            end
            sddf_pkg::ST_CONVERT:
            begin
                bcd_next  = {bcd_adj[sddf_pkg::BCD_W-2:0], mag_reg[sddf_pkg::MAG_W-1]};
                mag_next  = mag_reg << 1;
                step_next = step_reg + sddf_pkg::STEP_W'(1);
                if (step_reg == sddf_pkg::STEP_W'(sddf_pkg::MAG_W - 1))
                begin
                    pos_next   = '0;
                    blank_next = 1'b1;
                    state_next = sddf_pkg::ST_EMIT;
                end
            end
            sddf_pkg::ST_EMIT:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    glyph_next     = blank_now ? sddf_pkg::GLYPH_BLANK : code;
                    opos_next      = pos_reg;
                    olast_next     = (pos_reg == last_pos_reg);
                    blank_next     = blank_now;
                    pos_next       = pos_reg + 3'd1;
                    if (pos_reg == last_pos_reg)
                        state_next = sddf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sddf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sddf_pkg::ST_IDLE;
            step_reg      <= '0;
            pos_reg       <= '0;
            blank_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            pos_reg       <= pos_next;
            blank_reg     <= blank_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        bcd_reg      <= bcd_next;
        last_pos_reg <= last_pos_next;
        limit_reg    <= limit_next;
        neg_reg      <= neg_next;
        dec_reg      <= dec_next;
        glyph_reg    <= glyph_next;
        opos_reg     <= opos_next;
        olast_reg    <= olast_next;
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == sddf_pkg::ST_CONVERT) && (step_reg == '0))
        else $error("request did not start a conversion");

    a_emit_in_field: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sddf_pkg::ST_EMIT) |-> (pos_reg <= last_pos_reg))
        else $error("emit position beyond field");

    a_glyph_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (glyph_reg != 4'd2) && (glyph_reg != 4'd13) && (glyph_reg != 4'd15))
        else $error("unused glyph code emitted");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |=> $stable(opos_reg) && out_valid_reg)
        else $error("output register overwritten while stalled");
`endif

endmodule
